/* src/e2h_pkg.sv */
// Shared types, constants and arithmetic helpers for the equatorial to horizontal converter.
package e2h_pkg;

    localparam int FRAC = 30;
    localparam logic signed [33:0] CORDIC_K = 34'sd652032874;
    localparam logic [31:0] HALF_TURN = 32'h8000_0000;
    localparam logic [31:0] QUARTER_TURN = 32'h4000_0000;

    typedef logic signed [33:0] q30_t;
    typedef logic signed [33:0] zang_t;

    function automatic logic signed [33:0] atan_turn(input int i);
        logic signed [33:0] r;
        begin
            case (i)
                0: r = 34'sd536870912;
                1: r = 34'sd316933406;
                2: r = 34'sd167458907;
                3: r = 34'sd85004756;
                4: r = 34'sd42667331;
                5: r = 34'sd21354465;
                6: r = 34'sd10679838;
                7: r = 34'sd5340245;
                8: r = 34'sd2670163;
                9: r = 34'sd1335087;
                10: r = 34'sd667544;
                11: r = 34'sd333772;
                12: r = 34'sd166886;
                13: r = 34'sd83443;
                14: r = 34'sd41722;
                15: r = 34'sd20861;
                16: r = 34'sd10430;
                17: r = 34'sd5215;
                18: r = 34'sd2608;
                19: r = 34'sd1304;
                20: r = 34'sd652;
                21: r = 34'sd326;
                22: r = 34'sd163;
                23: r = 34'sd81;
                24: r = 34'sd41;
                25: r = 34'sd20;
                26: r = 34'sd10;
                27: r = 34'sd5;
                28: r = 34'sd3;
                29: r = 34'sd1;
                30: r = 34'sd1;
                default: r = 34'sd0;
            endcase
            return r;
        end
    endfunction

    // Q30 product, rounded half up; operands stay within about 2^31.
    function automatic q30_t qmul(input q30_t a, input q30_t b);
        logic signed [67:0] p;
        begin
            p = a * b + 68'sd536870912;
            return q30_t'(p >>> FRAC);
        end
    endfunction

endpackage

/* src/e2h_if.sv */
// Ready/valid channel interfaces for the converter.
interface e2h_in_if #(parameter int ANGLE_BITS = 24);
    logic valid;
    logic ready;
    logic [ANGLE_BITS-1:0] hour_angle;
    logic signed [ANGLE_BITS-1:0] declination;
    modport source (output valid, hour_angle, declination, input ready);
    modport sink (input valid, hour_angle, declination, output ready);
endinterface

interface e2h_out_if #(parameter int ANGLE_BITS = 24);
    logic valid;
    logic ready;
    logic [ANGLE_BITS-1:0] azimuth;
    logic signed [ANGLE_BITS-1:0] altitude;
    modport source (output valid, azimuth, altitude, input ready);
    modport sink (input valid, azimuth, altitude, output ready);
endinterface

/* src/equatorial_to_horizontal.sv */
// Equatorial to horizontal converter built on a CORDIC pipeline.
// Takes hour angle and declination, gives azimuth from north and altitude for the latitude
// in lat_reg, loaded from cfg_wdata on cfg_we. Unless the output stalls, the pipeline
// accepts one word every cycle. It holds three CORDIC chains (sine/cosine, azimuth,
// altitude) of one register per iteration plus product and rounding stages. A stalled
// output freezes the whole pipeline; write the latitude only while the pipeline is empty.
module equatorial_to_horizontal #(
    parameter int ANGLE_BITS = 24,
    parameter int CORDIC_STAGES = 24
) (
    input  logic clk,
    input  logic rst_n,
    input  logic cfg_we,
    input  logic [ANGLE_BITS-1:0] cfg_wdata,
    e2h_in_if.sink in_ch,
    e2h_out_if.source out_ch
);
    import e2h_pkg::*;

    localparam int NS = (CORDIC_STAGES > 32) ? 32 : CORDIC_STAGES;
    localparam int LAT = 3 * NS + 7;

    logic [ANGLE_BITS-1:0] lat_reg;
    logic [LAT-1:0] vld_reg;
    logic en;

    assign en = !out_ch.valid || out_ch.ready;
    assign in_ch.ready = en;
    assign out_ch.valid = vld_reg[LAT-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lat_reg <= '0;
            vld_reg <= '0;
        end
        else
        begin
            if (cfg_we)
                lat_reg <= cfg_wdata;
            if (en)
                vld_reg <= {vld_reg[LAT-2:0], in_ch.valid};
        end
    end

    function automatic logic [31:0] widen(input logic [ANGLE_BITS-1:0] a);
        logic [63:0] w;
        begin
            w = {32'd0, a} << (32 - ANGLE_BITS);
            return w[31:0];
        end
    endfunction

    function automatic logic [ANGLE_BITS-1:0] narrow(input logic [31:0] a);
        logic [32:0] r;
        begin
            if (ANGLE_BITS < 32)
                r = ({1'b0, a} + (33'd1 << (31 - ANGLE_BITS))) >> (32 - ANGLE_BITS);
            else
                r = {1'b0, a};
            return r[ANGLE_BITS-1:0];
        end
    endfunction

    // stage 0: fold angles into the right half plane
    logic [2:0] flip_reg [NS+1];
    q30_t rx [3][NS+1];
    q30_t ry [3][NS+1];
    zang_t rz [3][NS+1];
    logic [31:0] ang [3];

    assign ang[0] = widen(in_ch.hour_angle);
    assign ang[1] = widen(in_ch.declination);
    assign ang[2] = widen(lat_reg);

    genvar g, s;
    generate
        for (g = 0; g < 3; g++)
        begin : g_sc
            logic [31:0] a_adj;
            logic fl;
            q30_t x0_reg, y0_reg;
            zang_t z0_reg;
            assign fl = ((ang[g] + QUARTER_TURN) & HALF_TURN) != 32'd0;
            assign a_adj = fl ? ang[g] - HALF_TURN : ang[g];
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    x0_reg <= CORDIC_K;
                    y0_reg <= '0;
                    z0_reg <= zang_t'(signed'(a_adj));
                    flip_reg[0][g] <= fl;
                end
            end
            assign rx[g][0] = x0_reg;
            assign ry[g][0] = y0_reg;
            assign rz[g][0] = z0_reg;
            for (s = 0; s < NS; s++)
            begin : g_it
                e2h_rot_stage #(.SHIFT(s)) u_rot (
                    .clk(clk), .en(en),
                    .x_in(rx[g][s]), .y_in(ry[g][s]), .z_in(rz[g][s]),
                    .x_out(rx[g][s+1]), .y_out(ry[g][s+1]), .z_out(rz[g][s+1])
                );
            end
        end
        for (s = 0; s < NS; s++)
        begin : g_fl
            always_ff @(posedge clk)
            begin
                if (en)
                    flip_reg[s+1] <= flip_reg[s];
            end
        end
    endgenerate

    // products: two stages
    q30_t st, ct, sd, cd, sp, cp;
    assign st = flip_reg[NS][0] ? -ry[0][NS] : ry[0][NS];
    assign ct = flip_reg[NS][0] ? -rx[0][NS] : rx[0][NS];
    assign sd = flip_reg[NS][1] ? -ry[1][NS] : ry[1][NS];
    assign cd = flip_reg[NS][1] ? -rx[1][NS] : rx[1][NS];
    assign sp = flip_reg[NS][2] ? -ry[2][NS] : ry[2][NS];
    assign cp = flip_reg[NS][2] ? -rx[2][NS] : rx[2][NS];

    q30_t cdct_reg, spsd_reg, cpsd_reg, sa_reg, sp1_reg, cp1_reg;
    q30_t cz_reg, ca_reg, sa2_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cdct_reg <= qmul(cd, ct);
            spsd_reg <= qmul(sp, sd);
            cpsd_reg <= qmul(cp, sd);
            sa_reg <= qmul(cd, st);
            sp1_reg <= sp;
            cp1_reg <= cp;
            cz_reg <= spsd_reg + qmul(cp1_reg, cdct_reg);
            ca_reg <= qmul(sp1_reg, cdct_reg) - cpsd_reg;
            sa2_reg <= sa_reg;
        end
    end

    // azimuth vectoring chain
    q30_t ax [NS+1];
    q30_t ay [NS+1];
    zang_t az [NS+1];
    q30_t czp [NS+1];
    logic zero_a [NS+1];
    q30_t ax0_reg, ay0_reg;
    zang_t az0_reg;
    q30_t cz0_reg;
    logic zr0_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            zr0_reg <= (sa2_reg == '0) && (ca_reg == '0);
            cz0_reg <= cz_reg;
            if (ca_reg < 0)
            begin
                ax0_reg <= -ca_reg;
                ay0_reg <= -sa2_reg;
                az0_reg <= zang_t'({1'b0, HALF_TURN});
            end
            else
            begin
                ax0_reg <= ca_reg;
                ay0_reg <= sa2_reg;
                az0_reg <= '0;
            end
        end
    end
    assign ax[0] = ax0_reg;
    assign ay[0] = ay0_reg;
    assign az[0] = az0_reg;
    assign czp[0] = cz0_reg;
    assign zero_a[0] = zr0_reg;

    generate
        for (s = 0; s < NS; s++)
        begin : g_az
            q30_t czp_reg;
            logic zr_reg;
            e2h_vec_stage #(.SHIFT(s)) u_vec (
                .clk(clk), .en(en),
                .x_in(ax[s]), .y_in(ay[s]), .z_in(az[s]),
                .x_out(ax[s+1]), .y_out(ay[s+1]), .z_out(az[s+1])
            );
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    czp_reg <= czp[s];
                    zr_reg <= zero_a[s];
                end
            end
            assign czp[s+1] = czp_reg;
            assign zero_a[s+1] = zr_reg;
        end
    endgenerate

    // magnitude and azimuth word
    q30_t mag_reg, cz1_reg;
    logic [31:0] azw_reg;
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mag_reg <= zero_a[NS] ? q30_t'(0) : qmul(ax[NS], CORDIC_K);
            azw_reg <= (zero_a[NS] ? 32'd0 : az[NS][31:0]) + HALF_TURN;
            cz1_reg <= czp[NS];
        end
    end

    // altitude vectoring chain
    q30_t lx [NS+1];
    q30_t ly [NS+1];
    zang_t lz [NS+1];
    logic [31:0] azp [NS+1];
    logic zero_l [NS+1];
    q30_t lx0_reg, ly0_reg;
    zang_t lz0_reg;
    logic [31:0] azp0_reg;
    logic zl0_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            zl0_reg <= (cz1_reg == '0) && (mag_reg == '0);
            azp0_reg <= azw_reg;
            if (mag_reg < 0)
            begin
                lx0_reg <= -mag_reg;
                ly0_reg <= -cz1_reg;
                lz0_reg <= zang_t'({1'b0, HALF_TURN});
            end
            else
            begin
                lx0_reg <= mag_reg;
                ly0_reg <= cz1_reg;
                lz0_reg <= '0;
            end
        end
    end
    assign lx[0] = lx0_reg;
    assign ly[0] = ly0_reg;
    assign lz[0] = lz0_reg;
    assign azp[0] = azp0_reg;
    assign zero_l[0] = zl0_reg;

    generate
        for (s = 0; s < NS; s++)
        begin : g_alt
            logic [31:0] azp_reg;
            logic zl_reg;
            e2h_vec_stage #(.SHIFT(s)) u_vec (
                .clk(clk), .en(en),
                .x_in(lx[s]), .y_in(ly[s]), .z_in(lz[s]),
                .x_out(lx[s+1]), .y_out(ly[s+1]), .z_out(lz[s+1])
            );
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    azp_reg <= azp[s];
                    zl_reg <= zero_l[s];
                end
            end
            assign azp[s+1] = azp_reg;
            assign zero_l[s+1] = zl_reg;
        end
    endgenerate

    // round to output width
    logic [ANGLE_BITS-1:0] azo_reg, alto_reg;
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            azo_reg <= narrow(azp[NS]);
            alto_reg <= narrow(zero_l[NS] ? 32'd0 : lz[NS][31:0]);
        end
    end
    assign out_ch.azimuth = azo_reg;
    assign out_ch.altitude = alto_reg;

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(out_ch.azimuth))
        else $error("output word changed under stall");
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !out_ch.valid |-> in_ch.ready)
        else $error("pipeline stalled with empty output");
    a_flow: assert property (@(posedge clk) disable iff (!rst_n)
        in_ch.ready && !in_ch.valid |=> !vld_reg[0])
        else $error("bubble turned into a word");
endmodule

/* src/e2h_rot_stage.sv */
// One rotation-mode CORDIC iteration with a register, producing sine and cosine.
module e2h_rot_stage #(
    parameter int SHIFT = 0
) (
    input  logic clk,
    input  logic en,
    input  e2h_pkg::q30_t x_in,
    input  e2h_pkg::q30_t y_in,
    input  e2h_pkg::zang_t z_in,
    output e2h_pkg::q30_t x_out,
    output e2h_pkg::q30_t y_out,
    output e2h_pkg::zang_t z_out
);
    import e2h_pkg::*;

    q30_t x_next, y_next;
    zang_t z_next;
    q30_t x_reg, y_reg;
    zang_t z_reg;

    always_comb
    begin
        if (z_in >= 0)
        begin
            x_next = x_in - (y_in >>> SHIFT);
            y_next = y_in + (x_in >>> SHIFT);
            z_next = z_in - atan_turn(SHIFT);
        end
        else
        begin
            x_next = x_in + (y_in >>> SHIFT);
            y_next = y_in - (x_in >>> SHIFT);
            z_next = z_in + atan_turn(SHIFT);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg <= x_next;
            y_reg <= y_next;
            z_reg <= z_next;
        end
    end

    assign x_out = x_reg;
    assign y_out = y_reg;
    assign z_out = z_reg;
endmodule

/* src/e2h_vec_stage.sv */
// One vectoring-mode CORDIC iteration with a register, producing angle and length.
module e2h_vec_stage #(
    parameter int SHIFT = 0
) (
    input  logic clk,
    input  logic en,
    input  e2h_pkg::q30_t x_in,
    input  e2h_pkg::q30_t y_in,
    input  e2h_pkg::zang_t z_in,
    output e2h_pkg::q30_t x_out,
    output e2h_pkg::q30_t y_out,
    output e2h_pkg::zang_t z_out
);
    import e2h_pkg::*;

    q30_t x_next, y_next;
    zang_t z_next;
    q30_t x_reg, y_reg;
    zang_t z_reg;

    always_comb
    begin
        if (y_in > 0)
        begin
            x_next = x_in + (y_in >>> SHIFT);
            y_next = y_in - (x_in >>> SHIFT);
            z_next = z_in + atan_turn(SHIFT);
        end
        else
        begin
            x_next = x_in - (y_in >>> SHIFT);
            y_next = y_in + (x_in >>> SHIFT);
            z_next = z_in - atan_turn(SHIFT);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg <= x_next;
            y_reg <= y_next;
            z_reg <= z_next;
        end
    end

    assign x_out = x_reg;
    assign y_out = y_reg;
    assign z_out = z_reg;
endmodule
